>>> design/odo_pkg.sv
// Shared types, constants and tables of the differential-drive odometry block.
package odo_pkg;

    // Number of CORDIC micro-rotations per heading evaluation.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);

    // Angle and vector width inside the CORDIC unit.
    localparam int ANG_W = 34;

    // Angle constants in Q.28 and the CORDIC start gain in Q2.30.
    localparam logic signed [ANG_W-1:0] Q28_PI      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] Q28_HALF_PI = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] Q28_TWO_PI  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_GAIN    = 34'sd652032874;

    // Divider geometry: magnitude dividend and step time divisor.
    localparam int DIV_BITS = 64;
    localparam int DIV_CW   = $clog2(DIV_BITS);
    localparam int ST_W     = 24;

    // Configuration register indexes.
    typedef enum logic {
        REG_WHEEL_RADIUS = 1'b0,
        REG_TICK_ANGLE   = 1'b1
    } cfg_reg_t;

    // Main sequencer states.
    typedef enum logic [3:0] {
        S_IDLE, S_PL, S_PR, S_MEAN, S_HI, S_LO, S_DIST, S_CWAIT,
        S_MX, S_MY, S_YUP, S_DIV, S_DWAIT, S_COMMIT, S_DONE
    } odo_state_t;

    typedef enum logic [1:0] {C_IDLE, C_WRAP, C_FOLD, C_ITER} cordic_state_t;
    typedef enum logic {D_IDLE, D_RUN} div_state_t;

    // Status returned by the CORDIC unit.
    typedef struct packed {
        logic                    busy;
        logic signed [ANG_W-1:0] cos_v;
        logic signed [ANG_W-1:0] sin_v;
    } cordic_res_t;

    // Status returned by the divider.
    typedef struct packed {
        logic                busy;
        logic [DIV_BITS-1:0] quotient;
    } div_res_t;

    // Arctangent of 2^-i in Q.28.
    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd210828714;
            5'd1:  v = 34'sd124459457;
            5'd2:  v = 34'sd65760959;
            5'd3:  v = 34'sd33381290;
            5'd4:  v = 34'sd16755422;
            5'd5:  v = 34'sd8385879;
            5'd6:  v = 34'sd4193963;
            5'd7:  v = 34'sd2097109;
            5'd8:  v = 34'sd1048571;
            5'd9:  v = 34'sd524287;
            5'd10: v = 34'sd262144;
            5'd11: v = 34'sd131072;
            5'd12: v = 34'sd65536;
            5'd13: v = 34'sd32768;
            5'd14: v = 34'sd16384;
            5'd15: v = 34'sd8192;
            5'd16: v = 34'sd4096;
            5'd17: v = 34'sd2048;
            5'd18: v = 34'sd1024;
            5'd19: v = 34'sd512;
            5'd20: v = 34'sd256;
            5'd21: v = 34'sd128;
            5'd22: v = 34'sd64;
            5'd23: v = 34'sd32;
            5'd24: v = 34'sd16;
            5'd25: v = 34'sd8;
            5'd26: v = 34'sd4;
            5'd27: v = 34'sd2;
            5'd28: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/odo_cordic.sv
// Iterative CORDIC unit: range reduction, quadrant fold and rotation steps.
module odo_cordic import odo_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] angle,
    output cordic_res_t             res
);

    cordic_state_t           state_reg, state_next;
    logic signed [ANG_W-1:0] ang_reg, x_reg, y_reg;
    logic                    flip_reg;
    logic [CORDIC_IW-1:0]    iter_reg;
    logic signed [ANG_W-1:0] sx, sy;

    assign sx = x_reg >>> iter_reg;
    assign sy = y_reg >>> iter_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (start) state_next = C_WRAP;
            C_WRAP: if (ang_reg <= Q28_PI && ang_reg >= -Q28_PI) state_next = C_FOLD;
            C_FOLD: state_next = C_ITER;
            C_ITER: if (iter_reg == CORDIC_IW'(CORDIC_STEPS - 1)) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: one subtract per cycle while wrapping, one rotation per cycle after.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    ang_reg  <= angle;
                    x_reg    <= Q30_GAIN;
                    y_reg    <= '0;
                    flip_reg <= 1'b0;
                    iter_reg <= '0;
                end
            end
            C_WRAP: begin
                if (ang_reg > Q28_PI) begin
                    ang_reg <= ang_reg - Q28_TWO_PI;
                end else if (ang_reg < -Q28_PI) begin
                    ang_reg <= ang_reg + Q28_TWO_PI;
                end
            end
            C_FOLD: begin
                if (ang_reg > Q28_HALF_PI) begin
                    ang_reg  <= ang_reg - Q28_PI;
                    flip_reg <= 1'b1;
                end else if (ang_reg < -Q28_HALF_PI) begin
                    ang_reg  <= ang_reg + Q28_PI;
                    flip_reg <= 1'b1;
                end
            end
            C_ITER: begin
                if (!ang_reg[ANG_W-1]) begin
                    x_reg   <= x_reg - sy;
                    y_reg   <= y_reg + sx;
                    ang_reg <= ang_reg - atan_q28(5'(iter_reg));
                end else begin
                    x_reg   <= x_reg + sy;
                    y_reg   <= y_reg - sx;
                    ang_reg <= ang_reg + atan_q28(5'(iter_reg));
                end
                iter_reg <= iter_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Results carry the half-turn flip from the fold.
    assign res.busy  = (state_reg != C_IDLE);
    assign res.cos_v = flip_reg ? -x_reg : x_reg;
    assign res.sin_v = flip_reg ? -y_reg : y_reg;

endmodule

>>> design/odo_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module odo_divider import odo_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [ST_W-1:0]     divisor,
    output div_res_t            res
);

    div_state_t          state_reg, state_next;
    logic [DIV_BITS-1:0] quo_reg;
    logic [ST_W-1:0]     rem_reg, div_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic [ST_W:0]       trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[DIV_BITS-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_RUN;
            D_RUN:  if (cnt_reg == DIV_CW'(DIV_BITS - 1)) state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge aclk) begin
        if (state_reg == D_IDLE) begin
            if (start) begin
                quo_reg <= dividend;
                div_reg <= divisor;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
        end else begin
            rem_reg <= fits ? ST_W'(trial - {1'b0, div_reg}) : trial[ST_W-1:0];
            quo_reg <= {quo_reg[DIV_BITS-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign res.busy     = (state_reg != D_IDLE);
    assign res.quotient = quo_reg;

endmodule

>>> design/differential_drive_odometry_unit.sv
// Top level of the differential-drive odometry block: sequencer and shared multiplier.
//
// Input beats on s_* carry step time and encoder tick deltas plus the absolute
// heading; each beat yields exactly one result beat on m_*. The cfg_* channel
// writes wheel radius (index 0) and tick angle (index 1); it is always ready.
// Each item uses the shared 34x34 multiplier, the CORDIC unit (wrap, fold
// and CORDIC_STEPS rotations, overlapped with the distance products) and four
// divisions on the one-bit-per-cycle divider. s_tready is high only while the
// sequencer is idle. A zero step time skips the work and returns the stored
// state with m_tuser set. The result sits in an output register, so the next
// beat is accepted while it waits; if the receiver still stalls when the next
// result is ready, the sequencer holds it until m_tready. Synchronous active-low
// reset clears the pose, velocities, rates, wheel angles and both
// configuration registers.
module differential_drive_odometry_unit import odo_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // step_time, left_ticks, right_ticks, heading_in
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [351:0] m_tdata,   // pose_x, pose_y, pose_heading, linear_velocity,
                                    // angular_velocity, left_wheel_rate,
                                    // right_wheel_rate, left_wheel_angle,
                                    // right_wheel_angle
    output logic [0:0]   m_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    odo_state_t state_reg, state_next;

    // Configuration and captured item.
    logic [31:0]        radius_reg, tick_reg;
    logic [ST_W-1:0]    st_reg;
    logic signed [31:0] lt_reg, rt_reg, hd_reg;

    // Stored odometry state.
    logic signed [31:0] x_reg, y_reg, hs_reg, prev_reg;
    logic signed [31:0] linv_reg, angv_reg, lrate_reg, rrate_reg;
    logic signed [63:0] langle_reg, rangle_reg;

    // Working registers for one item.
    logic signed [63:0] pl_reg, al_reg, ar_reg;
    logic signed [63:0] prr_reg;
    logic [63:0]        mag_reg, hiprod_reg;
    logic               neg_reg;
    logic signed [32:0] dth_reg;
    logic signed [31:0] dist_reg;
    logic [1:0]         div_idx_reg;
    logic               div_neg_reg;
    logic               status_reg;
    logic signed [67:0] prod_reg;

    // Output register.
    logic         m_tvalid_reg;
    logic [351:0] m_tdata_reg;
    logic         m_tuser_reg;

    // Shared multiplier.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;

    // Units.
    cordic_res_t        cordic_res;
    div_res_t           div_res;
    logic signed [33:0] cordic_angle;
    logic signed [63:0] div_src;
    logic [63:0]        div_mag;
    logic signed [31:0] div_sat;

    // Combinational helpers.
    logic signed [63:0] pr_w, al_w, ar_w, mean_w;
    logic signed [64:0] sum65;
    logic signed [32:0] dth_w;
    logic [64:0]        psum;
    logic signed [31:0] dist_w;
    logic signed [67:0] step_sh;
    logic               out_free;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PL: begin
                mul_a = {{2{lt_reg[31]}}, lt_reg};
                mul_b = {2'b00, tick_reg};
            end
            S_PR: begin
                mul_a = {{2{rt_reg[31]}}, rt_reg};
                mul_b = {2'b00, tick_reg};
            end
            S_HI: begin
                mul_a = {2'b00, mag_reg[63:32]};
                mul_b = {2'b00, radius_reg};
            end
            S_LO: begin
                mul_a = {2'b00, mag_reg[31:0]};
                mul_b = {2'b00, radius_reg};
            end
            S_MX: begin
                mul_a = {{2{dist_reg[31]}}, dist_reg};
                mul_b = cordic_res.cos_v;
            end
            S_MY: begin
                mul_a = {{2{dist_reg[31]}}, dist_reg};
                mul_b = cordic_res.sin_v;
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Step angles, mean angle and heading change.
    assign pr_w   = prod_reg[63:0];
    assign al_w   = pl_reg >>> 4;
    assign ar_w   = pr_w >>> 4;
    assign sum65  = {al_w[63], al_w} + {ar_w[63], ar_w};
    assign mean_w = 64'(sum65 >>> 1);
    assign dth_w  = {hd_reg[31], hd_reg} - {prev_reg[31], prev_reg};
    assign cordic_angle = {{2{hs_reg[31]}}, hs_reg} + {{2{dth_w[32]}}, dth_w[32:1]};

    // Distance magnitude from the two partial products, then sign and clip.
    assign psum = {1'b0, hiprod_reg[59:0], 4'b0000} + {29'b0, prod_reg[63:28]};
    always_comb begin
        if (neg_reg) begin
            dist_w = (psum >= 65'd2147483648) ? 32'sh80000000 : -$signed(psum[31:0]);
        end else begin
            dist_w = (psum >= 65'd2147483647) ? 32'sh7FFFFFFF : $signed(psum[31:0]);
        end
    end

    assign step_sh = prod_reg >>> 30;

    // Dividend for the current division, as a magnitude.
    always_comb begin
        unique case (div_idx_reg)
            2'd0:    div_src = {{16{dist_reg[31]}}, dist_reg, 16'b0};
            2'd1:    div_src = {{27{dth_reg[32]}}, dth_reg, 4'b0};
            2'd2:    div_src = pl_reg;
            default: div_src = prr_reg;
        endcase
    end
    assign div_mag = div_src[63] ? 64'(-div_src) : div_src;

    always_comb begin
        if (div_neg_reg) begin
            div_sat = (div_res.quotient > 64'd2147483648) ? 32'sh80000000
                    : -$signed(div_res.quotient[31:0]);
        end else begin
            div_sat = (div_res.quotient > 64'd2147483647) ? 32'sh7FFFFFFF
                    : $signed(div_res.quotient[31:0]);
        end
    end

    odo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_MEAN),
        .angle   (cordic_angle),
        .res     (cordic_res)
    );

    odo_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_DIV),
        .dividend (div_mag),
        .divisor  (st_reg),
        .res      (div_res)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = (s_tdata[23:0] == '0) ? S_DONE : S_PL;
            S_PL:     state_next = S_PR;
            S_PR:     state_next = S_MEAN;
            S_MEAN:   state_next = S_HI;
            S_HI:     state_next = S_LO;
            S_LO:     state_next = S_DIST;
            S_DIST:   state_next = S_CWAIT;
            S_CWAIT:  if (!cordic_res.busy) state_next = S_MX;
            S_MX:     state_next = S_MY;
            S_MY:     state_next = S_YUP;
            S_YUP:    state_next = S_DIV;
            S_DIV:    state_next = S_DWAIT;
            S_DWAIT: begin
                if (!div_res.busy) begin
                    state_next = (div_idx_reg == 2'd3) ? S_COMMIT : S_DIV;
                end
            end
            S_COMMIT: state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            tick_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WHEEL_RADIUS: radius_reg <= cfg_data;
                REG_TICK_ANGLE:   tick_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item working registers.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    st_reg      <= s_tdata[23:0];
                    lt_reg      <= s_tdata[55:24];
                    rt_reg      <= s_tdata[87:56];
                    hd_reg      <= s_tdata[119:88];
                    status_reg  <= (s_tdata[23:0] == '0);
                    div_idx_reg <= '0;
                end
            end
            S_PR:    pl_reg <= prod_reg[63:0];
            S_MEAN: begin
                al_reg  <= al_w;
                ar_reg  <= ar_w;
                neg_reg <= mean_w[63];
                mag_reg <= mean_w[63] ? 64'(-mean_w) : mean_w;
                dth_reg <= dth_w;
            end
            S_LO:    hiprod_reg <= prod_reg[63:0];
            S_DIST:  dist_reg <= dist_w;
            S_DIV:   div_neg_reg <= div_src[63];
            S_DWAIT: if (!div_res.busy) div_idx_reg <= div_idx_reg + 1'b1;
            default: ;
        endcase
    end

    // Right step product, kept for its rate division.
    always_ff @(posedge aclk) begin
        if (state_reg == S_MEAN) begin
            prr_reg <= pr_w;
        end
    end

    // Odometry state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg      <= '0;
            y_reg      <= '0;
            hs_reg     <= '0;
            prev_reg   <= '0;
            linv_reg   <= '0;
            angv_reg   <= '0;
            lrate_reg  <= '0;
            rrate_reg  <= '0;
            langle_reg <= '0;
            rangle_reg <= '0;
        end else begin
            unique case (state_reg)
                S_MY:  x_reg <= sat32({{8{x_reg[31]}}, x_reg} + step_sh[39:0]);
                S_YUP: y_reg <= sat32({{8{y_reg[31]}}, y_reg} + step_sh[39:0]);
                S_DWAIT: begin
                    if (!div_res.busy) begin
                        unique case (div_idx_reg)
                            2'd0:    linv_reg  <= div_sat;
                            2'd1:    angv_reg  <= div_sat;
                            2'd2:    lrate_reg <= div_sat;
                            default: rrate_reg <= div_sat;
                        endcase
                    end
                end
                S_COMMIT: begin
                    hs_reg     <= sat32({{7{dth_reg[32]}}, dth_reg} + {{8{hs_reg[31]}}, hs_reg});
                    prev_reg   <= hd_reg;
                    langle_reg <= sat_add64(langle_reg, al_reg);
                    rangle_reg <= sat_add64(rangle_reg, ar_reg);
                end
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_tdata_reg <= {rangle_reg, langle_reg, rrate_reg, lrate_reg, angv_reg,
                            linv_reg, hs_reg, y_reg, x_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> bench/odometry_checker.sv
// Checker for the odometry block: watches the channels, predicts each result and compares it.
module odometry_checker import odo_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [351:0] m_tdata,
    input  logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [0:0]   status;
        logic [351:0] data;
    } pose_report_t;

    // Arctangent table for the predictor, Q.28.
    localparam longint ATAN_TAB [32] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

    logic [31:0] radius_q16, tick_q32;
    longint      pos_x, pos_y, head_acc, head_prev, lin_vel, ang_vel;
    longint      rate_l, rate_r, wangle_l, wangle_r;
    pose_report_t expected_poses[$];

    assign pending_count = expected_poses.size();

    // Floor shift; SystemVerilog >>> on signed longint already floors.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint add_clip64(longint a, longint b);
        longint lim_hi, lim_lo;
        lim_hi = 64'h7fffffffffffffff;
        lim_lo = 64'h8000000000000000;
        if (b > 0 && a > lim_hi - b) return lim_hi;
        if (b < 0 && a < lim_lo - b) return lim_lo;
        return a + b;
    endfunction

    // Travelled distance in Q16.16: magnitude truncated, then clipped.
    function automatic longint travel_q16(logic [31:0] r, longint a);
        logic [63:0] m, hi, lo, p;
        m  = (a < 0) ? -a : a;
        hi = m >> 32;
        lo = m & 64'hffffffff;
        p  = ((hi * r) << 4) + ((lo * r) >> 28);
        if (a < 0) return (p >= 64'd2147483648) ? -64'sd2147483648 : -longint'(p);
        return (p >= 64'd2147483647) ? 64'sd2147483647 : longint'(p);
    endfunction

    // Rotation-mode CORDIC with range reduction and half-turn fold.
    task automatic heading_vector(input longint ang, output longint c, output longint s);
        longint x, y, t;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        while (ang > 843314857) ang -= 1686629713;
        while (ang < -843314857) ang += 1686629713;
        if (ang > 421657428) begin
            ang -= 843314857;
            flip = 1;
        end else if (ang < -421657428) begin
            ang += 843314857;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (ang >= 0) begin
                t = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                ang -= ATAN_TAB[i];
            end else begin
                t = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                ang += ATAN_TAB[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the pose for one accepted input beat and queue the result.
    task automatic advance_pose(input logic [119:0] beat);
        longint st, lt, rt, hd, pl, pr, al, ar, mean, travel, dth, c, s;
        pose_report_t rep;
        st = beat[23:0];
        lt = $signed(beat[55:24]);
        rt = $signed(beat[87:56]);
        hd = $signed(beat[119:88]);
        rep.status = 1'b1;
        if (st != 0) begin
            pl   = lt * longint'({32'd0, tick_q32});
            pr   = rt * longint'({32'd0, tick_q32});
            al   = floor_shift(pl, 4);
            ar   = floor_shift(pr, 4);
            mean = floor_shift(al + ar, 1);
            travel = travel_q16(radius_q16, mean);
            dth  = hd - head_prev;
            heading_vector(head_acc + floor_shift(dth, 1), c, s);
            pos_x    = clip32(pos_x + floor_shift(travel * c, 30));
            pos_y    = clip32(pos_y + floor_shift(travel * s, 30));
            head_acc = clip32(head_acc + dth);
            lin_vel  = clip32(travel * 65536 / st);
            ang_vel  = clip32(dth * 16 / st);
            rate_l   = clip32(pl / st);
            rate_r   = clip32(pr / st);
            wangle_l = add_clip64(wangle_l, al);
            wangle_r = add_clip64(wangle_r, ar);
            head_prev = hd;
            rep.status = 1'b0;
        end
        rep.data = {wangle_r[63:0], wangle_l[63:0], rate_r[31:0], rate_l[31:0],
                    ang_vel[31:0], lin_vel[31:0], head_acc[31:0], pos_y[31:0],
                    pos_x[31:0]};
        expected_poses.push_back(rep);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Compare one result beat against the oldest expectation, field by field.
    task automatic check_pose(input logic [0:0] st, input logic [351:0] d);
        pose_report_t e;
        string names [9];
        names = '{"pose_x", "pose_y", "pose_heading", "linear_velocity",
                  "angular_velocity", "left_wheel_rate", "right_wheel_rate",
                  "left_wheel_angle", "right_wheel_angle"};
        if (expected_poses.size() == 0) begin
            report_mismatch("unexpected result beat", 0, 0);
            return;
        end
        e = expected_poses.pop_front();
        if (st !== e.status) report_mismatch("status", st, e.status);
        for (int f = 0; f < 7; f++)
            if (d[f*32 +: 32] !== e.data[f*32 +: 32])
                report_mismatch(names[f], d[f*32 +: 32], e.data[f*32 +: 32]);
        for (int f = 0; f < 2; f++)
            if (d[224 + f*64 +: 64] !== e.data[224 + f*64 +: 64])
                report_mismatch(names[7+f], d[224 + f*64 +: 64], e.data[224 + f*64 +: 64]);
    endtask

    initial fail_count = 0;

    // Sample every channel at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            radius_q16 = 0; tick_q32 = 0;
            pos_x = 0; pos_y = 0; head_acc = 0; head_prev = 0;
            lin_vel = 0; ang_vel = 0; rate_l = 0; rate_r = 0;
            wangle_l = 0; wangle_r = 0;
            expected_poses.delete();
        end else begin
            if (m_tvalid && m_tready) check_pose(m_tuser, m_tdata);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WHEEL_RADIUS) radius_q16 = cfg_data;
                else if (cfg_index == REG_TICK_ANGLE) tick_q32 = cfg_data;
            end
            if (s_tvalid && s_tready) advance_pose(s_tdata);
        end
    end
endmodule

>>> bench/testbench.sv
// Testbench top: clock, reset, stimulus for the odometry block and the final verdict.
module testbench import odo_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;   // step_time, left_ticks, right_ticks, heading_in
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [351:0] m_tdata;        // pose_x .. right_wheel_angle
    logic [0:0]   m_tuser;        // status
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    int           fail_count, pending_count;
    longint       cycle_count = 0;
    bit           sink_enable = 0;

    localparam longint CYCLE_LIMIT = 10000000;

    always #1 aclk = ~aclk;

    differential_drive_odometry_unit dut (.*);

    odometry_checker checker_i (.*);

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // Receiver side: random stalls, sometimes long ones.
    initial begin
        int g;
        @(posedge sink_enable);
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 0;
                repeat (g) @(negedge aclk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 30)) @(negedge aclk);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // Send one input beat, with a random gap ahead of it.
    task automatic send_step(input logic [23:0] st, input logic [31:0] lt,
                             input logic [31:0] rt, input logic [31:0] hd);
        int g;
        g = gap_len();
        if (g > 0) begin
            @(negedge aclk);
            s_tvalid <= 0;
            repeat (g - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= {hd, rt, lt, st};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_ticks();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return 32'($signed($urandom_range(0, 20000)) - 10000);
        endcase
    endfunction

    function automatic logic [23:0] rand_step_time();
        case ($urandom_range(0, 19))
            0: return 24'd0;
            1: return 24'($urandom);
            2: return 24'd1;
            default: return 24'($urandom_range(100, 2000));
        endcase
    endfunction

    initial begin
        logic [31:0] heading;
        logic [31:0] radii [4];
        logic [31:0] ticks [4];
        radii = '{32'd6554, 32'hffffffff, 32'd0, 32'h00010000};
        ticks = '{32'd2147483, 32'hffffffff, 32'd1, 32'd67108864};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        sink_enable = 1;

        // Directed: extremes of each field, zero step time and saturation.
        send_step(24'd0, 32'd5, 32'd5, 32'd100);
        drain();
        write_reg(REG_WHEEL_RADIUS, 32'd6554);
        write_reg(REG_TICK_ANGLE, 32'd2147483);
        send_step(24'd655, 32'd100, 32'd120, 32'd1000000);
        send_step(24'd0, 32'd1, 32'd1, 32'd0);
        send_step(24'hffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_step(24'd1, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_step(24'd1, 32'hffffffff, 32'h00000001, 32'h7fffffff);
        send_step(24'd1, 32'h80000000, 32'h80000000, 32'h80000000);
        send_step(24'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        drain();
        write_reg(REG_WHEEL_RADIUS, 32'hffffffff);
        write_reg(REG_TICK_ANGLE, 32'hffffffff);
        for (int k = 0; k < 6; k++)
            send_step(24'd1, 32'h7fffffff, 32'h7fffffff, k[0] ? 32'h7fffffff : 32'h80000000);
        for (int k = 0; k < 4; k++)
            send_step(24'd1, 32'h80000000, 32'h80000000, 32'd0);
        send_step(24'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        drain();

        // Random phases through several register settings.
        heading = 0;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 4) begin
                write_reg(REG_WHEEL_RADIUS, radii[ph]);
                write_reg(REG_TICK_ANGLE, ticks[ph]);
            end else begin
                write_reg(REG_WHEEL_RADIUS, $urandom);
                write_reg(REG_TICK_ANGLE, $urandom);
            end
            for (int n = 0; n < 190; n++) begin
                if ($urandom_range(0, 9) == 0) heading = $urandom;
                else heading = heading + 32'($signed($urandom_range(0, 2000000)) - 1000000);
                send_step(rand_step_time(), rand_ticks(), rand_ticks(), heading);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
